// ----- src/rsl_pkg.sv -----
// shared types and constants for the radial spotlight luminance block
// no dependencies; imported by every module of the block but rsl_queue

package rsl_pkg;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic
    {
        REG_CENTER_X = 1'b0,
        REG_CENTER_Y = 1'b1
    } rsl_reg_t;

    // spotlight center registers, two's complement
    localparam int CENTER_W = 14;

    // squared distance at or above this value always hits the decrease cap
    // (160 pixels squared); below it the square fits in SQ_W bits
    localparam int          SQ_W   = 15;
    localparam int unsigned SAT_SQ = 25600;

    // distance root: 8 integer plus 8 fractional bits below the cap
    localparam int ROOT_W = 16;

    // q1.16 factor arithmetic
    localparam int          FACTOR_W = 17;
    localparam int unsigned ONE_Q16  = 65536;
    localparam int unsigned MAX_DEC  = 52429;

    // classified request handed from the front end to the back end
    typedef struct packed
    {
        logic            sat;
        logic [SQ_W-1:0] sq;
    } rsl_dist_t;

endpackage

// ----- src/rsl_queue.sv -----
// small synchronous fifo built from flops, used between pipeline parts
// depends on nothing; DEPTH must be a power of two of at least 2

module rsl_queue #(
    parameter int W     = 32,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- src/rsl_front.sv -----
// front end: accepts pixels, forms the squared distance to the center
// and flags requests whose decrease is capped; uses rsl_pkg

module rsl_front #(
    parameter int COORD_BITS = 12,
    parameter int LUM_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [COORD_BITS-1:0]           pixel_x,
    input  logic [COORD_BITS-1:0]           pixel_y,
    input  logic [LUM_BITS-1:0]             lum_in,
    input  logic [rsl_pkg::CENTER_W-1:0]    center_x,
    input  logic [rsl_pkg::CENTER_W-1:0]    center_y,
    input  logic                            q_full,
    output logic                            q_push,
    output rsl_pkg::rsl_dist_t              q_dist,
    output logic [LUM_BITS-1:0]             q_lum
);

    import rsl_pkg::*;

    // signed difference width covers pixel range minus any center
    localparam int DXW = ((COORD_BITS > CENTER_W - 1) ? COORD_BITS : CENTER_W - 1) + 2;
    localparam int AW  = DXW - 1;
    localparam int SW  = 2 * AW + 1;

    logic            a_valid_reg;
    logic            a_valid_next;
    logic [AW-1:0]   adx_reg;
    logic [AW-1:0]   ady_reg;
    logic [LUM_BITS-1:0] a_lum_reg;

    logic            b_valid_reg;
    logic            b_valid_next;
    logic [2*AW-1:0] sqx_reg;
    logic [2*AW-1:0] sqy_reg;
    logic [LUM_BITS-1:0] b_lum_reg;

    logic            c_valid_reg;
    logic            c_valid_next;
    rsl_dist_t       c_dist_reg;
    logic [LUM_BITS-1:0] c_lum_reg;

    logic            a_rdy;
    logic            b_rdy;
    logic            c_rdy;
    logic [DXW-1:0]  dx;
    logic [DXW-1:0]  dy;
    logic [AW-1:0]   adx_next;
    logic [AW-1:0]   ady_next;
    logic [2*AW-1:0] sqx_next;
    logic [2*AW-1:0] sqy_next;
    logic [SW-1:0]   sum;
    rsl_dist_t       c_dist_next;

    assign c_rdy  = !c_valid_reg || !q_full;
    assign b_rdy  = !b_valid_reg || c_rdy;
    assign a_rdy  = !a_valid_reg || b_rdy;
    assign full   = !a_rdy;
    assign q_push = c_valid_reg && !q_full;
    assign q_dist = c_dist_reg;
    assign q_lum  = c_lum_reg;

    always_comb
    begin
        dx = {{(DXW - COORD_BITS){1'b0}}, pixel_x}
           - {{(DXW - CENTER_W){center_x[CENTER_W-1]}}, center_x};
        dy = {{(DXW - COORD_BITS){1'b0}}, pixel_y}
           - {{(DXW - CENTER_W){center_y[CENTER_W-1]}}, center_y};
        adx_next = dx[DXW-1] ? AW'(~dx + 1'b1) : dx[AW-1:0];
        ady_next = dy[DXW-1] ? AW'(~dy + 1'b1) : dy[AW-1:0];
        sqx_next = adx_reg * adx_reg;
        sqy_next = ady_reg * ady_reg;
        sum      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        c_dist_next.sat = (sum >= SW'(SAT_SQ));
        c_dist_next.sq  = sum[SQ_W-1:0];
    end

    always_comb
    begin
        a_valid_next = a_rdy ? push : a_valid_reg;
        b_valid_next = b_rdy ? a_valid_reg : b_valid_reg;
        c_valid_next = c_rdy ? b_valid_reg : c_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy)
        begin
            adx_reg   <= adx_next;
            ady_reg   <= ady_next;
            a_lum_reg <= lum_in;
        end
        if (b_rdy)
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            b_lum_reg <= a_lum_reg;
        end
        if (c_rdy)
        begin
            c_dist_reg <= c_dist_next;
            c_lum_reg  <= b_lum_reg;
        end
    end

endmodule

// ----- src/rsl_back.sv -----
// back end: pipelined square root, decrease and factor, luminance scaling,
// then a two-entry result fifo; uses rsl_pkg and rsl_queue

module rsl_back #(
    parameter int LUM_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                q_pop,
    input  rsl_pkg::rsl_dist_t  q_dist,
    input  logic [LUM_BITS-1:0] q_lum,
    output logic                empty,
    input  logic                pop,
    output logic [LUM_BITS-1:0] lum_out
);

    import rsl_pkg::*;

    localparam int NSTG   = ROOT_W;
    localparam int RADW   = 2 * ROOT_W;
    localparam int RAD_SH = 16;
    localparam int RW     = ROOT_W + 2;
    localparam int TW     = RW + 2;

    // decrease = (d8*64 + 25) / 50 via reciprocal multiply
    localparam int          DEC_SH   = 6;
    localparam int unsigned DEC_BIAS = 25;
    localparam int          XW       = ROOT_W + DEC_SH;
    localparam int unsigned RECIP    = 5368710;
    localparam int          RECIP_W  = 23;
    localparam int          RECIP_SH = 28;
    localparam int          PW       = XW + RECIP_W;
    localparam int          DEC_W    = 16;
    localparam int          MW       = LUM_BITS + FACTOR_W;

    logic                ben;
    logic                o_full;

    logic [NSTG-1:0]     sv_reg;
    logic [ROOT_W-1:0]   root_reg [NSTG];
    logic [RW-1:0]       rem_reg  [NSTG];
    logic [RADW-1:0]     rad_reg  [NSTG];
    logic [NSTG-1:0]     sat_reg;
    logic [LUM_BITS-1:0] lum_reg  [NSTG];

    logic [ROOT_W-1:0]   in_root  [NSTG];
    logic [RW-1:0]       in_rem   [NSTG];
    logic [RADW-1:0]     in_rad   [NSTG];
    logic [ROOT_W-1:0]   root_next [NSTG];
    logic [RW-1:0]       rem_next  [NSTG];
    logic [RADW-1:0]     rad_next  [NSTG];
    logic [TW-1:0]       t_val    [NSTG];
    logic [TW-1:0]       trial    [NSTG];
    logic                ge       [NSTG];

    logic                rc_valid_reg;
    logic [PW-1:0]       rc_prod_reg;
    logic                rc_sat_reg;
    logic [LUM_BITS-1:0] rc_lum_reg;
    logic [XW-1:0]       x_val;
    logic [PW-1:0]       rc_prod_next;

    logic                fc_valid_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [FACTOR_W-1:0] factor_next;
    logic [DEC_W-1:0]    dec;
    logic [LUM_BITS-1:0] fc_lum_reg;

    logic                mv_valid_reg;
    logic [MW-1:0]       mprod_reg;
    logic [MW-1:0]       mprod_next;

    // whole back pipeline stalls only when its last stage cannot drain
    assign ben   = !mv_valid_reg || !o_full;
    assign q_pop = !q_empty && ben;

    // one root bit per stage, restoring digit recurrence
    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (k == 0)
            begin
                in_root[k] = '0;
                in_rem[k]  = '0;
                in_rad[k]  = {{(RADW - SQ_W - RAD_SH){1'b0}}, q_dist.sq, {RAD_SH{1'b0}}};
            end
            else
            begin
                in_root[k] = root_reg[k-1];
                in_rem[k]  = rem_reg[k-1];
                in_rad[k]  = rad_reg[k-1];
            end
            t_val[k]     = {in_rem[k], in_rad[k][RADW-1 -: 2]};
            trial[k]     = TW'({in_root[k], 2'b01});
            ge[k]        = (t_val[k] >= trial[k]);
            rem_next[k]  = ge[k] ? RW'(t_val[k] - trial[k]) : RW'(t_val[k]);
            root_next[k] = {in_root[k][ROOT_W-2:0], ge[k]};
            rad_next[k]  = {in_rad[k][RADW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg       <= '0;
            rc_valid_reg <= 1'b0;
            fc_valid_reg <= 1'b0;
            mv_valid_reg <= 1'b0;
        end
        else if (ben)
        begin
            sv_reg       <= {sv_reg[NSTG-2:0], q_pop};
            rc_valid_reg <= sv_reg[NSTG-1];
            fc_valid_reg <= rc_valid_reg;
            mv_valid_reg <= fc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
                rad_reg[k]  <= rad_next[k];
                if (k == 0)
                begin
                    sat_reg[k] <= q_dist.sat;
                    lum_reg[k] <= q_lum;
                end
                else
                begin
                    sat_reg[k] <= sat_reg[k-1];
                    lum_reg[k] <= lum_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        x_val        = {root_reg[NSTG-1], {DEC_SH{1'b0}}} + XW'(DEC_BIAS);
        rc_prod_next = PW'(x_val) * PW'(RECIP);
        dec          = rc_sat_reg ? DEC_W'(MAX_DEC) : rc_prod_reg[RECIP_SH +: DEC_W];
        factor_next  = FACTOR_W'(ONE_Q16) - {1'b0, dec};
        mprod_next   = MW'(fc_lum_reg) * MW'(factor_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            rc_prod_reg <= rc_prod_next;
            rc_sat_reg  <= sat_reg[NSTG-1];
            rc_lum_reg  <= lum_reg[NSTG-1];
            factor_reg  <= factor_next;
            fc_lum_reg  <= rc_lum_reg;
            mprod_reg   <= mprod_next;
        end
    end

    rsl_queue #(
        .W     (LUM_BITS),
        .DEPTH (2)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mv_valid_reg),
        .wdata (mprod_reg[16 +: LUM_BITS]),
        .full  (o_full),
        .pop   (pop),
        .rdata (lum_out),
        .empty (empty)
    );

endmodule

// ----- src/radial_spotlight_luminance_core.sv -----
// top level of the radial spotlight luminance block
// depends on rsl_pkg, rsl_front, rsl_queue and rsl_back

// Pixel requests enter through a queue-like port: an item is taken at a
// clock edge with push high and full low. Results leave the same way: the
// oldest result sits on lum_out while empty is low and is taken with pop.
// One result comes out per request, in request order.
// From acceptance to its result showing, a request passes through
// three front stages (distance, squares, classify), a four-entry queue,
// sixteen square-root stages (one root bit each), three stages for the
// decrease, factor and luminance multiply, then a two-entry result fifo.
// Throughput is one request per cycle while pop keeps up; no stage iterates.
// When pop stays low the back end fills and stalls, the middle queue fills,
// then the front end stalls and full rises; nothing is dropped.
// The spotlight center is set through the APB port (center_x at 0,
// center_y at 4); write it only while no request is in flight.
// Reset clears both center registers and empties every stage and queue.

module radial_spotlight_luminance_core #(
    parameter int COORD_BITS = 12,
    parameter int LUM_BITS   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [COORD_BITS-1:0]            pixel_x,
    input  logic [COORD_BITS-1:0]            pixel_y,
    input  logic [LUM_BITS-1:0]              lum_in,
    input  logic                             pop,
    output logic                             empty,
    output logic [LUM_BITS-1:0]              lum_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rsl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rsl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rsl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    import rsl_pkg::*;

    localparam int QW = $bits(rsl_dist_t) + LUM_BITS;

    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_x_next;
    logic [CENTER_W-1:0] center_y_reg;
    logic [CENTER_W-1:0] center_y_next;
    logic [CENTER_W-1:0] rd_val;
    logic                wr_en;
    rsl_reg_t            reg_sel;

    logic                mq_push;
    logic                mq_full;
    logic                mq_pop;
    logic                mq_empty;
    rsl_dist_t           f_dist;
    logic [LUM_BITS-1:0] f_lum;
    logic [QW-1:0]       mq_wdata;
    logic [QW-1:0]       mq_rdata;
    rsl_dist_t           b_dist;
    logic [LUM_BITS-1:0] b_lum;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = rsl_reg_t'(paddr[REG_SEL_BIT]);

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        rd_val        = center_x_reg;
        unique case (reg_sel)
            REG_CENTER_X:
            begin
                rd_val = center_x_reg;
                if (wr_en)
                begin
                    center_x_next = pwdata[CENTER_W-1:0];
                end
            end
            REG_CENTER_Y:
            begin
                rd_val = center_y_reg;
                if (wr_en)
                begin
                    center_y_next = pwdata[CENTER_W-1:0];
                end
            end
            default:
            begin
                rd_val = center_x_reg;
            end
        endcase
        prdata = {{(APB_DATA_W - CENTER_W){rd_val[CENTER_W-1]}}, rd_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
        end
    end

    rsl_front #(
        .COORD_BITS (COORD_BITS),
        .LUM_BITS   (LUM_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .lum_in   (lum_in),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .q_full   (mq_full),
        .q_push   (mq_push),
        .q_dist   (f_dist),
        .q_lum    (f_lum)
    );

    assign mq_wdata        = {f_dist, f_lum};
    assign {b_dist, b_lum} = mq_rdata;

    rsl_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .wdata (mq_wdata),
        .full  (mq_full),
        .pop   (mq_pop),
        .rdata (mq_rdata),
        .empty (mq_empty)
    );

    rsl_back #(
        .LUM_BITS (LUM_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mq_empty),
        .q_pop   (mq_pop),
        .q_dist  (b_dist),
        .q_lum   (b_lum),
        .empty   (empty),
        .pop     (pop),
        .lum_out (lum_out)
    );

endmodule

// ----- src/rsl_checker.sv -----
// port-level checks for the radial spotlight luminance block
// depends on rsl_pkg; bound to radial_spotlight_luminance_core below

module rsl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           full,
    input logic                           empty,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [rsl_pkg::APB_ADDR_W-1:0] paddr,
    input logic [rsl_pkg::APB_DATA_W-1:0] pwdata,
    input logic [rsl_pkg::APB_DATA_W-1:0] prdata
);

    import rsl_pkg::*;

    logic wr;

    assign wr = psel && penable && pwrite;

    // reset leaves no result waiting and the input open
    a_reset_state: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not cleared during reset");

    // a center_x write reads back on the next cycle
    a_readback_x: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && paddr[REG_SEL_BIT] == 1'b0) ##1 (!wr && paddr[REG_SEL_BIT] == 1'b0)
        |-> prdata[CENTER_W-1:0] == $past(pwdata[CENTER_W-1:0]))
        else $error("center_x readback mismatch");

    // a center_y write reads back on the next cycle
    a_readback_y: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && paddr[REG_SEL_BIT] == 1'b1) ##1 (!wr && paddr[REG_SEL_BIT] == 1'b1)
        |-> prdata[CENTER_W-1:0] == $past(pwdata[CENTER_W-1:0]))
        else $error("center_y readback mismatch");

    // centers read back sign extended
    a_sign_ext: assert property (@(posedge clk)
        prdata[APB_DATA_W-1:CENTER_W] == {(APB_DATA_W - CENTER_W){prdata[CENTER_W-1]}})
        else $error("center readback not sign extended");

endmodule

bind radial_spotlight_luminance_core rsl_checker u_rsl_checker (.*);
